/* sv/touch_threshold_debounce_core_assert.svh */
`ifndef TOUCH_THRESHOLD_DEBOUNCE_CORE_ASSERT_SVH
`define TOUCH_THRESHOLD_DEBOUNCE_CORE_ASSERT_SVH

// Checks a property at every rising edge outside reset.
`define TTD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks a property at the rising edge that follows any edge at which reset is held.
`define TTD_ASSERT_IN_RESET(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) !rstn |=> prop) else $error(msg);

`endif

/* sv/ttd_pkg.sv */
package ttd_pkg;

  localparam int unsigned NumSensorsDefault = 8;

  localparam int unsigned IndexWidth     = 3;
  localparam int unsigned CountWidth     = 13;
  localparam int unsigned TimeWidth      = 32;
  localparam int unsigned CfgWidth       = 16;
  localparam int unsigned ThresholdWidth = 17;
  localparam int unsigned MaskWidth      = 8;

  localparam logic [CfgWidth-1:0]       DebounceReset  = 16'd50;
  localparam logic [CfgWidth-1:0]       OffsetReset    = 16'd0;
  localparam logic [ThresholdWidth-1:0] ThresholdReset = 17'd50;

  // floor(x / 5) as (x * Div5Recip) >> Div5Shift, exact for any 13-bit x.
  localparam logic [15:0]  Div5Recip = 16'd52429;
  localparam int unsigned  Div5Shift = 18;
  localparam int unsigned  Div5ProdWidth = CountWidth + 16;

  typedef enum logic [0:0] {
    REG_DEBOUNCE_MS        = 1'b0,
    REG_CALIBRATION_OFFSET = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    CMD_SAMPLE    = 1'b0,
    CMD_CALIBRATE = 1'b1
  } command_e;

endpackage

/* sv/touch_threshold_debounce_core.sv */
// Touch qualifier for up to NUM_SENSORS sensors. Each transfer on the input
// channel either samples one sensor (compare against its threshold, debounce
// against the millisecond time) or calibrates its threshold to
// floor(count * 6 / 5) + calibration_offset. Every input transfer yields
// exactly one output transfer. One item is accepted per cycle unless the
// output is stalled: all per-sensor state sits in flip-flops and is read
// and updated by a single pass of logic between the input register and the
// output register. Configuration writes take effect at the next edge and
// should be made while no item is in flight.
module touch_threshold_debounce_core #(
  parameter int unsigned NUM_SENSORS = ttd_pkg::NumSensorsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [ttd_pkg::CfgWidth-1:0]        cfg_wdata_i,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [ttd_pkg::IndexWidth-1:0]      sensor_index_i,
  input  logic [ttd_pkg::CountWidth-1:0]      count_i,
  input  logic [ttd_pkg::TimeWidth-1:0]       now_ms_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                raw_touched_o,
  output logic                                sensor_touched_o,
  output logic [ttd_pkg::MaskWidth-1:0]       touch_mask_o,
  output logic                                any_touched_o,
  output logic [ttd_pkg::IndexWidth-1:0]      first_touch_o
);

  logic [ttd_pkg::CfgWidth-1:0] debounce_q;
  logic [ttd_pkg::CfgWidth-1:0] offset_q;

  logic                               s_valid_q;
  logic                               s_cmd_q;
  logic [ttd_pkg::IndexWidth-1:0]     s_idx_q;
  logic [ttd_pkg::CountWidth-1:0]     s_count_q;
  logic [ttd_pkg::TimeWidth-1:0]      s_now_q;

  logic [ttd_pkg::ThresholdWidth-1:0] thr_q [NUM_SENSORS];
  logic [ttd_pkg::TimeWidth-1:0]      ct_q  [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]             last_raw_q;
  logic [NUM_SENSORS-1:0]             deb_q;
  logic [NUM_SENSORS-1:0]             deb_d;

  logic                               out_valid_q;
  logic                               raw_q;
  logic                               sensor_q;
  logic [ttd_pkg::MaskWidth-1:0]      mask_q;
  logic                               any_q;
  logic [ttd_pkg::IndexWidth-1:0]     first_q;

  logic                               accept;
  logic                               advance;
  logic                               is_sample;
  logic                               is_cal;
  logic [NUM_SENSORS-1:0]             hit;
  logic                               in_range;
  logic [ttd_pkg::ThresholdWidth-1:0] sel_thr;
  logic [ttd_pkg::TimeWidth-1:0]      sel_ct;
  logic                               sel_last;
  logic                               sel_deb;
  logic                               raw;
  logic                               changed;
  logic [ttd_pkg::TimeWidth-1:0]      elapsed;
  logic                               follow;
  logic                               new_deb;
  logic [ttd_pkg::Div5ProdWidth-1:0]  div_prod;
  logic [ttd_pkg::ThresholdWidth-1:0] cal_thr;
  logic [ttd_pkg::MaskWidth-1:0]      mask;
  logic                               any;
  logic [ttd_pkg::IndexWidth-1:0]     first;

  assign advance    = s_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= ttd_pkg::DebounceReset;
      offset_q   <= ttd_pkg::OffsetReset;
    end else if (cfg_we_i) begin
      unique case (ttd_pkg::cfg_reg_e'(cfg_index_i))
        ttd_pkg::REG_DEBOUNCE_MS:        debounce_q <= cfg_wdata_i;
        ttd_pkg::REG_CALIBRATION_OFFSET: offset_q   <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (accept) begin
      s_valid_q <= 1'b1;
    end else if (advance) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_cmd_q   <= command_i;
      s_idx_q   <= sensor_index_i;
      s_count_q <= count_i;
      s_now_q   <= now_ms_i;
    end
  end

  assign is_cal    = s_cmd_q == ttd_pkg::CMD_CALIBRATE;
  assign is_sample = !is_cal;

  always_comb begin
    hit      = '0;
    sel_thr  = '0;
    sel_ct   = '0;
    sel_last = 1'b0;
    sel_deb  = 1'b0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      hit[i] = 32'(s_idx_q) == i;
      if (hit[i]) begin
        sel_thr  = thr_q[i];
        sel_ct   = ct_q[i];
        sel_last = last_raw_q[i];
        sel_deb  = deb_q[i];
      end
    end
  end

  assign in_range = |hit;
  assign raw      = is_sample && in_range &&
                    (ttd_pkg::ThresholdWidth'(s_count_q) > sel_thr);
  assign changed  = raw != sel_last;
  assign elapsed  = s_now_q - sel_ct;
  assign follow   = !changed && (elapsed > ttd_pkg::TimeWidth'(debounce_q));
  assign new_deb  = follow ? raw : sel_deb;

  assign div_prod = ttd_pkg::Div5ProdWidth'(s_count_q) *
                    ttd_pkg::Div5ProdWidth'(ttd_pkg::Div5Recip);
  assign cal_thr  = ttd_pkg::ThresholdWidth'(s_count_q) +
                    ttd_pkg::ThresholdWidth'(div_prod[ttd_pkg::Div5ProdWidth-1:
                                                      ttd_pkg::Div5Shift]) +
                    ttd_pkg::ThresholdWidth'(offset_q);

  always_comb begin
    deb_d = deb_q;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (hit[i] && is_sample) begin
        deb_d[i] = new_deb;
      end
    end
  end

  always_comb begin
    mask  = '0;
    any   = 1'b0;
    first = '0;
    for (int i = NUM_SENSORS - 1; i >= 0; i--) begin
      if (deb_d[i]) begin
        any   = 1'b1;
        first = ttd_pkg::IndexWidth'(i);
        if (i < ttd_pkg::MaskWidth) begin
          mask[i % ttd_pkg::MaskWidth] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        thr_q[i] <= ttd_pkg::ThresholdReset;
        ct_q[i]  <= '0;
      end
      last_raw_q <= '0;
      deb_q      <= '0;
    end else if (advance) begin
      deb_q <= deb_d;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (hit[i]) begin
          if (is_cal) begin
            thr_q[i] <= cal_thr;
          end else begin
            last_raw_q[i] <= raw;
            if (changed) begin
              ct_q[i] <= s_now_q;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      raw_q    <= raw;
      sensor_q <= in_range && (is_sample ? new_deb : sel_deb);
      mask_q   <= mask;
      any_q    <= any;
      first_q  <= first;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign raw_touched_o    = raw_q;
  assign sensor_touched_o = sensor_q;
  assign touch_mask_o     = mask_q;
  assign any_touched_o    = any_q;
  assign first_touch_o    = first_q;

endmodule

/* sv/ttd_checker.sv */
`include "touch_threshold_debounce_core_assert.svh"

module ttd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ttd_pkg::MaskWidth-1:0] touch_mask_o,
  input logic                          any_touched_o,
  input logic [ttd_pkg::IndexWidth-1:0] first_touch_o
);

  `TTD_ASSERT_IN_RESET(a_no_result_in_reset, clk_i, rst_ni, !out_valid_o, "result offered during reset")

  `TTD_ASSERT(a_result_held, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result withdrawn before transfer")

  `TTD_ASSERT(a_any_matches_mask, clk_i, rst_ni, out_valid_o |-> (any_touched_o == (touch_mask_o != '0)), "any_touched disagrees with touch_mask")

  `TTD_ASSERT(a_first_is_lowest, clk_i, rst_ni, out_valid_o && any_touched_o |-> touch_mask_o[first_touch_o] && ((touch_mask_o & ~(8'hFF << first_touch_o)) == 8'h00), "first_touch is not the lowest touched sensor")

endmodule

bind touch_threshold_debounce_core ttd_checker u_ttd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .touch_mask_o  (touch_mask_o),
  .any_touched_o (any_touched_o),
  .first_touch_o (first_touch_o)
);

/* tb/touch_threshold_debounce_core_tb.sv */
`timescale 1ns / 100ps

module touch_threshold_debounce_core_tb;
  import ttd_pkg::*;

  localparam int unsigned NumSensors = NumSensorsDefault;
  localparam int unsigned MaxCount   = 8191;
  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned ItemsPerPhase = 340;

  typedef struct packed {
    logic                  raw_touched;
    logic                  sensor_touched;
    logic [MaskWidth-1:0]  touch_mask;
    logic                  any_touched;
    logic [IndexWidth-1:0] first_touch;
  } touch_result_t;

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_EVERY_FOURTH,
    RX_SPARSE
  } rx_pattern_e;

  class touch_scoreboard;
    logic [CfgWidth-1:0]       debounce_ms;
    logic [CfgWidth-1:0]       calibration_offset;
    logic [ThresholdWidth-1:0] threshold [NumSensors];
    bit                        last_raw [NumSensors];
    bit                        debounced [NumSensors];
    logic [TimeWidth-1:0]      change_time [NumSensors];
    touch_result_t             expected_q [$];
    int unsigned               errors;

    function new();
      debounce_ms        = DebounceReset;
      calibration_offset = OffsetReset;
      errors             = 0;
      for (int i = 0; i < NumSensors; i++) begin
        threshold[i]   = ThresholdReset;
        last_raw[i]    = 1'b0;
        debounced[i]   = 1'b0;
        change_time[i] = '0;
      end
    endfunction

    function void write_reg(cfg_reg_e r, logic [CfgWidth-1:0] value);
      case (r)
        REG_DEBOUNCE_MS:        debounce_ms = value;
        REG_CALIBRATION_OFFSET: calibration_offset = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function void note_input(command_e cmd, logic [IndexWidth-1:0] idx,
                             logic [CountWidth-1:0] cnt, logic [TimeWidth-1:0] now);
      touch_result_t             r;
      logic [ThresholdWidth-1:0] scaled;
      logic [TimeWidth-1:0]      elapsed;
      r = '0;
      if (idx < NumSensors) begin
        if (cmd == CMD_CALIBRATE) begin
          scaled = ThresholdWidth'(cnt) * 17'd6 / 17'd5;
          threshold[idx] = scaled + ThresholdWidth'(calibration_offset);
        end else begin
          r.raw_touched = ThresholdWidth'(cnt) > threshold[idx];
          if (r.raw_touched != last_raw[idx]) begin
            change_time[idx] = now;
          end
          elapsed = now - change_time[idx];
          if (elapsed > TimeWidth'(debounce_ms)) begin
            debounced[idx] = r.raw_touched;
          end
          last_raw[idx] = r.raw_touched;
        end
        r.sensor_touched = debounced[idx];
      end
      for (int i = NumSensors - 1; i >= 0; i--) begin
        if (debounced[i]) begin
          r.any_touched = 1'b1;
          r.first_touch = 3'(i);
          if (i < MaskWidth) begin
            r.touch_mask[i] = 1'b1;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    task check_result(touch_result_t got);
      touch_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("output transfer with nothing expected: %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.raw_touched != want.raw_touched)
        report($sformatf("raw_touched %0d, expected %0d", got.raw_touched, want.raw_touched));
      if (got.sensor_touched != want.sensor_touched)
        report($sformatf("sensor_touched %0d, expected %0d",
                         got.sensor_touched, want.sensor_touched));
      if (got.touch_mask != want.touch_mask)
        report($sformatf("touch_mask %h, expected %h", got.touch_mask, want.touch_mask));
      if (got.any_touched != want.any_touched)
        report($sformatf("any_touched %0d, expected %0d", got.any_touched, want.any_touched));
      if (got.first_touch != want.first_touch)
        report($sformatf("first_touch %0d, expected %0d", got.first_touch, want.first_touch));
    endtask
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic                  cfg_index_i    = 1'b0;
  logic [CfgWidth-1:0]   cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  command_i      = 1'b0;
  logic [IndexWidth-1:0] sensor_index_i = '0;
  logic [CountWidth-1:0] count_i        = '0;
  logic [TimeWidth-1:0]  now_ms_i       = '0;
  logic                  out_ready_i    = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  raw_touched_o;
  logic                  sensor_touched_o;
  logic [MaskWidth-1:0]  touch_mask_o;
  logic                  any_touched_o;
  logic [IndexWidth-1:0] first_touch_o;

  touch_scoreboard      sb;
  int unsigned          burst_left  = 0;
  bit                   sender_gaps = 1'b1;
  logic [TimeWidth-1:0] clock_ms    = '0;
  bit                   finger [NumSensors];
  int unsigned          rx_cycle    = 0;
  rx_pattern_e          rx_pattern  = RX_OPEN;

  touch_threshold_debounce_core #(
    .NUM_SENSORS(NumSensors)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .sensor_index_i  (sensor_index_i),
    .count_i         (count_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .raw_touched_o   (raw_touched_o),
    .sensor_touched_o(sensor_touched_o),
    .touch_mask_o    (touch_mask_o),
    .any_touched_o   (any_touched_o),
    .first_touch_o   (first_touch_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 113 == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(RX_OPEN, RX_SPARSE));
    end
    case (rx_pattern)
      RX_OPEN:         out_ready_i <= 1'b1;
      RX_COIN:         out_ready_i <= 1'($urandom_range(0, 1));
      RX_EVERY_FOURTH: out_ready_i <= (rx_cycle % 4 == 0);
      default:         out_ready_i <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_input(command_e'(command_i), sensor_index_i, count_i, now_ms_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(touch_result_t'({raw_touched_o, sensor_touched_o, touch_mask_o,
                                         any_touched_o, first_touch_o}));
      end
    end
  end

  task automatic send_item(command_e cmd, logic [IndexWidth-1:0] idx,
                           logic [CountWidth-1:0] cnt, logic [TimeWidth-1:0] now);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    sensor_index_i <= idx;
    count_i        <= cnt;
    now_ms_i       <= now;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [CfgWidth-1:0] debounce, logic [CfgWidth-1:0] offset);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_DEBOUNCE_MS;
    cfg_wdata_i <= debounce;
    @(posedge clk_i);
    sb.write_reg(REG_DEBOUNCE_MS, debounce);
    @(negedge clk_i);
    cfg_index_i <= REG_CALIBRATION_OFFSET;
    cfg_wdata_i <= offset;
    @(posedge clk_i);
    sb.write_reg(REG_CALIBRATION_OFFSET, offset);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CountWidth-1:0] count_for(logic [IndexWidth-1:0] idx, bit touch);
    int unsigned thr;
    int unsigned lo;
    int unsigned hi;
    thr = sb.threshold[idx];
    if (touch && thr < MaxCount) begin
      lo = thr + 1;
      hi = (thr + 600 > MaxCount) ? MaxCount : thr + 600;
    end else if (!touch) begin
      hi = (thr > MaxCount) ? MaxCount : thr;
      lo = (hi > 600) ? hi - 600 : 0;
    end else begin
      lo = 0;
      hi = MaxCount;
    end
    if ($urandom_range(0, 7) == 0) begin
      return touch ? CountWidth'(lo) : CountWidth'(hi);
    end
    return CountWidth'($urandom_range(lo, hi));
  endfunction

  task automatic random_item();
    int unsigned           sel;
    logic [IndexWidth-1:0] idx;
    logic [CountWidth-1:0] cnt;
    sel = $urandom_range(0, 99);
    idx = IndexWidth'($urandom_range(0, NumSensors - 1));
    if (sel < 8) begin
      if ($urandom_range(0, 1) == 0) begin
        cnt = CountWidth'($urandom_range(0, MaxCount));
      end else begin
        cnt = CountWidth'($urandom_range(0, 5000));
      end
      send_item(CMD_CALIBRATE, idx, cnt, clock_ms);
    end else if (sel < 13) begin
      send_item(CMD_SAMPLE, idx, CountWidth'($urandom_range(0, MaxCount)), $urandom());
    end else begin
      if ($urandom_range(0, 5) == 0) begin
        finger[idx] = !finger[idx];
      end
      if ($urandom_range(0, 24) == 0) begin
        clock_ms += $urandom_range(0, 140000);
      end else begin
        clock_ms += $urandom_range(0, 8);
      end
      send_item(CMD_SAMPLE, idx, count_for(idx, finger[idx]), clock_ms);
    end
  endtask

  task automatic run_phase(logic [CfgWidth-1:0] debounce, logic [CfgWidth-1:0] offset,
                           logic [NumSensors-1:0] cal_mask, bit gaps);
    sender_gaps = gaps;
    set_config(debounce, offset);
    for (int s = 0; s < NumSensors; s++) begin
      if (cal_mask[s]) begin
        send_item(CMD_CALIBRATE, IndexWidth'(s), CountWidth'($urandom_range(200, 4000)),
                  clock_ms);
      end
    end
    for (int n = 0; n < ItemsPerPhase; n++) begin
      random_item();
      if (n == ItemsPerPhase / 2) begin
        drain();
      end
    end
    drain();
  endtask

  initial begin
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(CMD_SAMPLE,    3'd0, 13'd0,    32'd0);
    send_item(CMD_SAMPLE,    3'd0, 13'd51,   32'd10);
    send_item(CMD_SAMPLE,    3'd0, 13'd8191, 32'd60);
    send_item(CMD_SAMPLE,    3'd0, 13'd51,   32'd61);
    send_item(CMD_SAMPLE,    3'd7, 13'd50,   32'd100);
    send_item(CMD_CALIBRATE, 3'd7, 13'd8191, 32'd0);
    send_item(CMD_SAMPLE,    3'd7, 13'd8191, 32'd200);
    send_item(CMD_CALIBRATE, 3'd3, 13'd5000, 32'd300);
    send_item(CMD_SAMPLE,    3'd3, 13'd6001, 32'hFFFF_FFF0);
    send_item(CMD_SAMPLE,    3'd3, 13'd6001, 32'h0000_0030);
    send_item(CMD_SAMPLE,    3'd0, 13'd0,    32'd1000);
    send_item(CMD_SAMPLE,    3'd0, 13'd0,    32'd1100);
    send_item(CMD_CALIBRATE, 3'd5, 13'd0,    32'd0);
    send_item(CMD_SAMPLE,    3'd5, 13'd1,    32'hFFFF_FFFF);
    send_item(CMD_SAMPLE,    3'd5, 13'd0,    32'h0000_0000);
    send_item(CMD_CALIBRATE, 3'd6, 13'd4,    32'd0);
    send_item(CMD_CALIBRATE, 3'd1, 13'd5,    32'd0);
    send_item(CMD_SAMPLE,    3'd1, 13'd7,    32'h8000_0000);
    send_item(CMD_SAMPLE,    3'd1, 13'd7,    32'h8000_0033);
    send_item(CMD_SAMPLE,    3'd2, 13'd51,   32'd5);
    send_item(CMD_SAMPLE,    3'd4, 13'd51,   32'd5);
    send_item(CMD_SAMPLE,    3'd2, 13'd51,   32'd56);
    send_item(CMD_SAMPLE,    3'd4, 13'd51,   32'd55);
    drain();

    clock_ms = 32'd2000;
    run_phase(16'd0, 16'hFFFF, 8'h07, 1'b1);
    run_phase(16'hFFFF, 16'd0, 8'hFF, 1'b1);
    clock_ms = 32'hFFFF_F000;
    run_phase(CfgWidth'($urandom_range(1, 300)), CfgWidth'($urandom_range(0, 3000)),
              8'hFF, 1'b1);
    run_phase(16'd50, 16'd0, 8'hFF, 1'b0);

    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report("results still outstanding at the end of the run");
    end
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
